// ===== hw/rtl/mbpm_pkg.sv =====
// mbpm_pkg: shared types and codes for the MIDI bank and parameter number merger
// no dependencies; used by the channel interfaces and the top level

package mbpm_pkg;

	// input event kinds
	localparam logic [1:0] EV_CC    = 2'd0;
	localparam logic [1:0] EV_PGM   = 2'd1;

	// result kinds
	localparam logic [2:0] OUT_CC    = 3'd0;
	localparam logic [2:0] OUT_PGM   = 3'd1;
	localparam logic [2:0] OUT_OTHER = 3'd2;
	localparam logic [2:0] OUT_RPN   = 3'd3;
	localparam logic [2:0] OUT_NRPN  = 3'd4;

	// controller numbers
	localparam logic [7:0] CC_BANK_MSB   = 8'd0;
	localparam logic [7:0] CC_DATA_ENTRY = 8'd6;
	localparam logic [7:0] CC_BANK_LSB   = 8'd32;
	localparam logic [7:0] CC_NRPN_LSB   = 8'd98;
	localparam logic [7:0] CC_NRPN_MSB   = 8'd99;
	localparam logic [7:0] CC_RPN_LSB    = 8'd100;
	localparam logic [7:0] CC_RPN_MSB    = 8'd101;

	// field widths
	localparam int KIND_W  = 2;
	localparam int OKIND_W = 3;
	localparam int CHAN_W  = 5;
	localparam int KEY_W   = 8;
	localparam int OKEY_W  = 22;
	localparam int VAL_W   = 7;

	// one channel's stored numbers, one memory word
	typedef struct packed {
		logic [6:0] bank_hi;
		logic [6:0] bank_lo;
		logic [6:0] rpn_hi;
		logic [6:0] rpn_lo;
		logic [6:0] nrpn_hi;
		logic [6:0] nrpn_lo;
	} chan_state_t;

endpackage

// ===== hw/rtl/mbpm_ev_if.sv =====
// mbpm_ev_if: valid/ready channel carrying one decoded MIDI event request
// depends on mbpm_pkg

interface mbpm_ev_if;
	logic                          valid;
	logic                          ready;
	logic [mbpm_pkg::KIND_W-1:0]   event_kind;
	logic [mbpm_pkg::CHAN_W-1:0]   channel;
	logic [mbpm_pkg::KEY_W-1:0]    key;
	logic [mbpm_pkg::VAL_W-1:0]    value;

	modport source (output valid, event_kind, channel, key, value, input ready);
	modport sink (input valid, event_kind, channel, key, value, output ready);
endinterface

// ===== hw/rtl/mbpm_res_if.sv =====
// mbpm_res_if: valid/ready channel carrying one merged result request
// depends on mbpm_pkg

interface mbpm_res_if;
	logic                          valid;
	logic                          ready;
	logic [mbpm_pkg::OKIND_W-1:0]  out_kind;
	logic [mbpm_pkg::CHAN_W-1:0]   out_channel;
	logic [mbpm_pkg::OKEY_W-1:0]   out_key;
	logic [mbpm_pkg::VAL_W-1:0]    out_value;

	modport source (output valid, out_kind, out_channel, out_key, out_value, input ready);
	modport sink (input valid, out_kind, out_channel, out_key, out_value, output ready);
endinterface

// ===== hw/rtl/mbpm_ram.sv =====
// mbpm_ram: generic single write port, single read port RAM with registered read
// no dependencies

module mbpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/midi_bank_and_param_number_merger_unit.sv =====
// midi_bank_and_param_number_merger_unit: top level of the bank / RPN / NRPN merger
// depends on mbpm_pkg, mbpm_ev_if, mbpm_res_if, mbpm_ram

// Takes one decoded MIDI event per cycle and gives at most one result per event,
// through stage 1 and the output register. Per-channel bank and parameter numbers
// live in one memory word per channel; an event reads its channel's word when it is
// accepted and the update is written back as the event leaves stage 1, with the last write
// forwarded so back-to-back events on one channel see each other. The sustained rate
// is one event per cycle; the output register stalls the pipe only while a result is
// held by the sink. Bank select, RPN and NRPN number controllers are absorbed and give
// no result. Per-channel valid bits make the whole state read as zero right after reset.
module midi_bank_and_param_number_merger_unit #(
	parameter int CHANNELS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	mbpm_ev_if.sink      ev,
	mbpm_res_if.source   res
);
	import mbpm_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ST_W  = $bits(chan_state_t);

	// stage 1 registers
	logic                 valid_s1;
	logic [KIND_W-1:0]    kind_s1;
	logic [CHAN_W-1:0]    chan_s1;
	logic [KEY_W-1:0]     key_s1;
	logic [VAL_W-1:0]     val_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 chan_ok_s1;
	logic                 ent_vld_s1;
	logic                 fwd_hit_s1;
	chan_state_t          fwd_data_s1;

	// control and output state
	logic                 rpn_sel_q;
	logic [CHANNELS-1:0]  ent_vld_q;
	logic                 res_valid_q;
	logic [OKIND_W-1:0]   res_kind_q;
	logic [CHAN_W-1:0]    res_chan_q;
	logic [OKEY_W-1:0]    res_key_q;
	logic [VAL_W-1:0]     res_val_q;

	logic                 accept;
	logic                 advance_s1;
	logic [CHAN_W-1:0]    ch_m1;
	logic [IDX_W-1:0]     rd_idx;
	logic                 rd_chan_ok;
	logic [ST_W-1:0]      ram_rdata;
	chan_state_t          cur_st;
	chan_state_t          new_st;
	logic                 swallow_s1;
	logic                 upd_s1;
	logic                 ram_we;
	logic                 rpn_sel_nxt;
	logic [OKIND_W-1:0]   okind;
	logic [OKEY_W-1:0]    okey;
	logic [OKEY_W-1:0]    pgm_m1;

	// handshake: stage 1 drains into the output register or is absorbed
	assign advance_s1 = valid_s1 && (swallow_s1 || !res_valid_q || res.ready);
	assign ev.ready   = !valid_s1 || advance_s1;
	assign accept     = ev.valid && ev.ready;

	// read address from the one-based channel
	assign ch_m1      = ev.channel - CHAN_W'(1);
	assign rd_idx     = ch_m1[IDX_W-1:0];
	assign rd_chan_ok = (ev.channel >= CHAN_W'(1)) && (ev.channel <= CHAN_W'(CHANNELS));

	mbpm_ram #(
		.WIDTH (ST_W),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (new_st),
		.re    (accept),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= ev.event_kind;
			chan_s1     <= ev.channel;
			key_s1      <= ev.key;
			val_s1      <= ev.value;
			idx_s1      <= rd_idx;
			chan_ok_s1  <= rd_chan_ok;
			ent_vld_s1  <= ent_vld_q[rd_idx];
			fwd_hit_s1  <= ram_we && (idx_s1 == rd_idx);
			fwd_data_s1 <= new_st;
		end
	end

	// current channel word: forwarded write, memory, or zero
	always_comb begin
		if (!chan_ok_s1) begin
			cur_st = '0;
		end else if (fwd_hit_s1) begin
			cur_st = fwd_data_s1;
		end else if (ent_vld_s1) begin
			cur_st = chan_state_t'(ram_rdata);
		end else begin
			cur_st = '0;
		end
	end

	// absorbed controllers and state update
	always_comb begin
		new_st      = cur_st;
		swallow_s1  = 1'b0;
		rpn_sel_nxt = rpn_sel_q;
		if (kind_s1 == EV_CC) begin
			case (key_s1)
				CC_BANK_MSB: begin
					new_st.bank_hi = val_s1;
					swallow_s1     = 1'b1;
				end
				CC_BANK_LSB: begin
					new_st.bank_lo = val_s1;
					swallow_s1     = 1'b1;
				end
				CC_RPN_MSB: begin
					new_st.rpn_hi = val_s1;
					swallow_s1    = 1'b1;
					rpn_sel_nxt   = 1'b1;
				end
				CC_RPN_LSB: begin
					new_st.rpn_lo = val_s1;
					swallow_s1    = 1'b1;
					rpn_sel_nxt   = 1'b1;
				end
				CC_NRPN_MSB: begin
					new_st.nrpn_hi = val_s1;
					swallow_s1     = 1'b1;
					rpn_sel_nxt    = 1'b0;
				end
				CC_NRPN_LSB: begin
					new_st.nrpn_lo = val_s1;
					swallow_s1     = 1'b1;
					rpn_sel_nxt    = 1'b0;
				end
				default: begin
					swallow_s1 = 1'b0;
				end
			endcase
		end
	end

	assign upd_s1 = advance_s1 && swallow_s1;
	assign ram_we = upd_s1 && chan_ok_s1;

	// result forming
	assign pgm_m1 = OKEY_W'(key_s1) - OKEY_W'(1);

	always_comb begin
		okey  = OKEY_W'(key_s1);
		okind = OUT_OTHER;
		if (kind_s1 == EV_CC) begin
			okind = OUT_CC;
			if (key_s1 == CC_DATA_ENTRY) begin
				if (rpn_sel_q) begin
					okind = OUT_RPN;
					okey  = OKEY_W'({cur_st.rpn_hi, cur_st.rpn_lo});
				end else begin
					okind = OUT_NRPN;
					okey  = OKEY_W'({cur_st.nrpn_hi, cur_st.nrpn_lo});
				end
			end
		end else if (kind_s1 == EV_PGM) begin
			okind = OUT_PGM;
			okey  = (pgm_m1 | OKEY_W'({cur_st.bank_hi, cur_st.bank_lo, 7'd0}))
				+ OKEY_W'(1);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rpn_sel_q   <= 1'b0;
			ent_vld_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance_s1) begin
				valid_s1 <= 1'b0;
			end
			if (upd_s1) begin
				rpn_sel_q <= rpn_sel_nxt;
			end
			if (ram_we) begin
				ent_vld_q[idx_s1] <= 1'b1;
			end
			if (advance_s1 && !swallow_s1) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance_s1 && !swallow_s1) begin
			res_kind_q <= okind;
			res_chan_q <= chan_s1;
			res_key_q  <= okey;
			res_val_q  <= val_s1;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.out_kind    = res_kind_q;
	assign res.out_channel = res_chan_q;
	assign res.out_key     = res_key_q;
	assign res.out_value   = res_val_q;

	// checks
	a_no_write_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> chan_ok_s1 && valid_s1)
		else $error("state write for a channel out of range");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request lost before stage 1");

	a_absorbed_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && swallow_s1 && !res_valid_q) |=> !res_valid_q)
		else $error("absorbed controller produced a result");

	a_fwd_only_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ram_we) |=> !fwd_hit_s1)
		else $error("forward hit without a write");
endmodule
